/* hw/rtl/scz_pkg.sv */
// Shared constants and types for the scope capture block.
`default_nettype none
package scz_pkg;
    localparam int RING_DEPTH  = 8192;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int WEIGHT_W    = 16;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ARM   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_LATCH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_BORDER = 2'd3;

    localparam logic [9:0] WIDTH_RST  = 10'd399;
    localparam logic [9:0] HEIGHT_RST = 10'd250;
    localparam logic [5:0] BORDER_RST = 6'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM_CHK,
        S_ARM_DIV,
        S_COL_MUL,
        S_COL_SUB,
        S_COL_SCL,
        S_COL_FIN
    } state_t;
endpackage
`default_nettype wire

/* hw/rtl/scz_div.sv */
// Radix-2 restoring divider for the crossing weight, one quotient bit per cycle.
`default_nettype none
module scz_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [scz_pkg::SAMPLE_BITS-1:0] num,
    input  wire logic [scz_pkg::SAMPLE_BITS-1:0] den,
    output logic                               done,
    output logic [scz_pkg::WEIGHT_W-1:0]       quot
);
    import scz_pkg::*;

    localparam int CNT_W = $clog2(WEIGHT_W + 1);

    logic                   run_reg, run_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SAMPLE_BITS:0]   rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] den_reg;
    logic [WEIGHT_W-1:0]    q_reg, q_next;
    logic [SAMPLE_BITS:0]   shifted;
    logic                   ge;

    // remainder stays below den, so the shift never overflows
    assign shifted = {rem_reg[SAMPLE_BITS-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        done     = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = {1'b0, num};
        end
        else if (run_reg)
        begin
            rem_next = ge ? shifted - {1'b0, den_reg} : shifted;
            q_next   = {q_reg[WEIGHT_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WEIGHT_W - 1))
            begin
                run_next = 1'b0;
            end
        end
        done = run_reg && (cnt_reg == CNT_W'(WEIGHT_W - 1));
    end

    assign quot = {q_reg[WEIGHT_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
        begin
            den_reg <= den;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/scope_capture_zero_cross_trigger.sv */
// Top level: sample ring, trigger search and column row computation.
// Usage:
//   start/busy command channel: a word is taken at a clock edge with start high
//   and busy low. Every word gives one result, shown for one cycle with done high.
//   Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken.
// Timing:
//   write sample: result in the cycle after accept, busy stays low (1 item/cycle).
//   arm, latch off, and command 3: result next cycle, no busy.
//   arm, latch on: walks back through the ring one step per read (two read ports)
//     until a rising zero crossing (then the serial divider runs) or a full circle.
//   read column: memory read, then S_COL_MUL, S_COL_SUB, S_COL_SCL and S_COL_FIN.
// The ring holds RING_DEPTH samples in one synchronous memory. Entries never
// written read as zero: the write pointer and a wrap flag mark what is filled,
// so no clearing pass is needed after reset.
// Reset clears pointers, weight, config and the sequencer; results cannot be
// stalled by the receiver, done is a single-cycle strobe.
`default_nettype none
module scope_capture_zero_cross_trigger (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      command,
    input  wire logic signed [scz_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [9:0]                      column,
    output logic                                 done,
    output logic [1:0]                           kind,
    output logic signed [scz_pkg::SAMPLE_BITS-1:0] sample_echo,
    output logic                                 trigger_found,
    output logic [13:0]                          row_q4,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [9:0]                      cfg_data
);
    import scz_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int M_W      = SB + 18;
    localparam int D_W      = SB + 19;
    localparam int P_W      = D_W + 11;
    localparam int T_W      = P_W + 2;
    localparam int ROW_SH   = SB + 12;

    // config
    logic       latch_reg;
    logic [9:0] width_reg, height_reg;
    logic [5:0] border_reg;

    // state
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, view_reg, p_reg;
    logic               full_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic               cv_reg;

    // ring memory
    logic [SB-1:0]      ring [RING_DEPTH];
    logic [SB-1:0]      rd_a_reg, rd_b_reg;
    logic               av_reg, bv_reg;

    // row pipeline
    logic signed [10:0]  span_reg;
    logic signed [M_W-1:0] m0_reg, m1_reg;
    logic signed [D_W-1:0] d_reg;
    logic signed [P_W-1:0] prod_reg;

    // row arithmetic: s = y0*(1-w) + y1*w, row = (1-s)*span/2 + border, Q4
    logic signed [T_W-1:0] t_sum;
    logic signed [T_W-1:0] row_full;
    logic                  prod_tot_neg;

    // result
    logic               done_reg;
    logic [1:0]         kind_reg;
    logic [SB-1:0]      echo_reg;
    logic               found_reg;
    logic [13:0]        row_reg;

    // control
    logic               accept;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr_a, rd_addr_b;
    logic               div_start, div_done;
    logic [WEIGHT_W-1:0] div_q;

    logic [PTR_W-1:0]   p_arm, p_dec, col_idx;
    logic signed [SB-1:0] ya, yb;
    logic               rising;
    logic [SB-1:0]      neg_y0, dden;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;

    assign p_arm   = wp_reg - PTR_W'(width_reg);
    assign p_dec   = p_reg - 1'b1;
    assign col_idx = view_reg + PTR_W'(column);

    assign ya     = av_reg ? $signed(rd_a_reg) : '0;
    assign yb     = bv_reg ? $signed(rd_b_reg) : '0;
    assign rising = (ya < 0) && (yb > 0);
    assign neg_y0 = SB'(-ya);
    assign dden   = SB'(yb - ya);

    scz_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (neg_y0),
        .den   (dden),
        .done  (div_done),
        .quot  (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_ARM && latch_reg)
                begin
                    state_next = S_ARM_CHK;
                end
                else if (accept && command == CMD_READ)
                begin
                    state_next = S_COL_MUL;
                end
            end
            S_ARM_CHK:
            begin
                if (rising)
                begin
                    state_next = S_ARM_DIV;
                end
                else if (p_dec == wp_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ARM_DIV: if (div_done) state_next = S_IDLE;
            S_COL_MUL: state_next = S_COL_SUB;
            S_COL_SUB: state_next = S_COL_SCL;
            S_COL_SCL: state_next = S_COL_FIN;
            S_COL_FIN: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr_a = p_reg;
        rd_addr_b = p_reg + 1'b1;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_ARM && latch_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr_a = p_arm;
                    rd_addr_b = p_arm + 1'b1;
                end
                else if (accept && command == CMD_READ)
                begin
                    rd_en     = 1'b1;
                    rd_addr_a = col_idx;
                    rd_addr_b = col_idx + 1'b1;
                end
            end
            S_ARM_CHK:
            begin
                if (rising)
                begin
                    div_start = 1'b1;
                end
                else if (p_dec != wp_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr_a = p_dec;
                    rd_addr_b = p_reg;
                end
            end
            default: ;
        endcase
    end

    // ring memory, two read ports
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_WRITE)
        begin
            ring[wp_reg] <= sample;
        end
        if (rd_en)
        begin
            rd_a_reg <= ring[rd_addr_a];
            rd_b_reg <= ring[rd_addr_b];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg <= 1'b0;
            bv_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            av_reg <= full_reg || (rd_addr_a < wp_reg);
            bv_reg <= full_reg || (rd_addr_b < wp_reg);
        end
    end

    // config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= 1'b0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            border_reg <= BORDER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LATCH:  latch_reg  <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_BORDER: border_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer and view state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            full_reg  <= 1'b0;
            view_reg  <= '0;
            p_reg     <= '0;
            w_reg     <= '0;
            cv_reg    <= 1'b1;
            done_reg  <= 1'b0;
            kind_reg  <= '0;
            echo_reg  <= '0;
            found_reg <= 1'b0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= command;
                        echo_reg  <= '0;
                        found_reg <= 1'b0;
                        row_reg   <= '0;
                        case (command)
                            CMD_WRITE:
                            begin
                                done_reg <= 1'b1;
                                echo_reg <= sample;
                                wp_reg   <= wp_reg + 1'b1;
                                if (wp_reg == PTR_W'(RING_DEPTH - 1))
                                begin
                                    full_reg <= 1'b1;
                                end
                            end
                            CMD_ARM:
                            begin
                                w_reg  <= '0;
                                cv_reg <= 1'b1;
                                p_reg  <= p_arm;
                                if (!latch_reg)
                                begin
                                    view_reg <= p_arm;
                                    done_reg <= 1'b1;
                                end
                            end
                            CMD_READ: ;
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end
                S_ARM_CHK:
                begin
                    if (!rising)
                    begin
                        p_reg <= p_dec;
                        if (p_dec == wp_reg)
                        begin
                            // walked full circle: flat view
                            view_reg <= p_dec;
                            cv_reg   <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
                S_ARM_DIV:
                begin
                    if (div_done)
                    begin
                        view_reg  <= p_reg;
                        w_reg     <= div_q;
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                    end
                end
                S_COL_FIN:
                begin
                    done_reg <= 1'b1;
                    if (prod_tot_neg)
                    begin
                        row_reg <= '0;
                    end
                    else if (row_full > T_W'(16383))
                    begin
                        row_reg <= 14'h3FFF;
                    end
                    else
                    begin
                        row_reg <= row_full[13:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign t_sum = T_W'(prod_reg)
                 + (T_W'(1) <<< (ROW_SH - 1))
                 + ($signed({{(T_W-6){1'b0}}, border_reg}) <<< (ROW_SH + 4));
    assign prod_tot_neg = t_sum < 0;
    assign row_full     = t_sum >>> ROW_SH;

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_READ)
        begin
            span_reg <= $signed({1'b0, height_reg}) - $signed({4'b0, border_reg, 1'b0});
        end
        if (state_reg == S_COL_MUL)
        begin
            if (cv_reg)
            begin
                m0_reg <= M_W'(ya * $signed({1'b0, (17'h10000 - {1'b0, w_reg})}));
                m1_reg <= M_W'(yb * $signed({2'b0, w_reg}));
            end
            else
            begin
                m0_reg <= '0;
                m1_reg <= '0;
            end
        end
        if (state_reg == S_COL_SUB)
        begin
            d_reg <= (D_W'(1) <<< (SB + 15)) - (D_W'(m0_reg) + D_W'(m1_reg));
        end
        if (state_reg == S_COL_SCL)
        begin
            prod_reg <= P_W'(d_reg * span_reg);
        end
    end

    assign done          = done_reg;
    assign kind          = kind_reg;
    assign sample_echo   = echo_reg;
    assign trigger_found = found_reg;
    assign row_q4        = row_reg;
endmodule
`default_nettype wire
